[src/kvt_pkg.sv]
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the key/value table
// Holds the field widths, request and status codes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

   // default sizes
   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int VALUE_BYTES_DEF   = 20;

   // field widths
   localparam int OP_W         = 2;
   localparam int KEY_W        = 32;
   localparam int VALUE_FULL_W = 160;
   localparam int STATUS_W     = 2;

   // stream widths, padded to whole bytes
   localparam int REQ_W   = 200;
   localparam int RSP_W   = 168;
   localparam int RSP_PAD = RSP_W - STATUS_W - VALUE_FULL_W;

   // request codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

[src/kvt_ram.sv]
// ----------------------------------------------------------------------------
// kvt_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ram #(
   parameter int WIDTH = kvt_pkg::KEY_W + 8 * kvt_pkg::VALUE_BYTES_DEF,
   parameter int DEPTH = kvt_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/key_value_table.sv]
// a result is registered once the scan has found the key or compared the last entry and the
//   result register is free, so a hit early in the scan ends it sooner, and an earlier result
//   still held by rsp_tready low delays it
// a new request is taken only once the sequencer is idle again, after the last result is
//   registered; the single key comparator walks the entry memory one entry a cycle
// reset: synchronous, clears all valid marks (table empty) and the control state
// ----------------------------------------------------------------------------
// key_value_table: bounded associative table, signed 32-bit key to value
// Insert, search and delete by a sequential scan of the entry memory with
// one shared key comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table #(
   parameter int TABLE_ENTRIES = kvt_pkg::TABLE_ENTRIES_DEF,
   parameter int VALUE_BYTES   = kvt_pkg::VALUE_BYTES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request stream
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // fields from bit 0: operation[2], key[32], value_bytes_0_7[64],
   // value_bytes_8_15[64], value_bytes_16_19[32], zero pad[6]
   input  wire logic [kvt_pkg::REQ_W-1:0] req_tdata,
   // result stream
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // fields from bit 0: status[2], found_value_0_7[64],
   // found_value_8_15[64], found_value_16_19[32], zero pad[6]
   output logic [kvt_pkg::RSP_W-1:0]      rsp_tdata
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int VALUE_W = 8 * VALUE_BYTES;
   localparam int ENTRY_W = kvt_pkg::KEY_W + VALUE_W;

   // sequencer
   kvt_pkg::state_type state_ff, state_in;

   // latched request
   logic [kvt_pkg::OP_W-1:0]  op_ff, op_in;
   logic [kvt_pkg::KEY_W-1:0] key_ff, key_in;
   logic [VALUE_W-1:0]        val_ff, val_in;

   // scan bookkeeping
   logic [CNT_W-1:0] idx_ff, idx_in;          // next entry to read
   logic             cmp_pend_ff, cmp_pend_in; // read data due this cycle
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;   // entry of that read data
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;         // lowest free entry seen
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [VALUE_W-1:0] found_ff, found_in;     // value of the matching entry

   // valid marks, one flop per entry
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [kvt_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [kvt_pkg::VALUE_FULL_W-1:0]    rsp_value_ff, rsp_value_in;

   // entry memory: key in the low bits, value above
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [kvt_pkg::KEY_W-1:0] rd_key;
   logic [VALUE_W-1:0]        rd_value;

   logic             scan_issue;
   logic             match;
   logic             finish_go;
   logic [IDX_W-1:0] wr_idx;
   logic [kvt_pkg::VALUE_FULL_W-1:0] req_value_full;

   kvt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_key         = ram_rdata[kvt_pkg::KEY_W-1:0];
   assign rd_value       = ram_rdata[ENTRY_W-1:kvt_pkg::KEY_W];
   assign req_value_full = req_tdata[kvt_pkg::OP_W + kvt_pkg::KEY_W +: kvt_pkg::VALUE_FULL_W];

   // only an idle sequencer takes a request; a waiting result does not block it
   assign req_tready = (state_ff == kvt_pkg::ST_IDLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{kvt_pkg::RSP_PAD{1'b0}}, rsp_value_ff, rsp_status_ff};

   // existing key overwrites in place, else lowest free entry
   assign wr_idx = hit_ff ? hit_idx_ff : free_idx_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      cmp_pend_in   = cmp_pend_ff;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      found_in      = found_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_idx;
      ram_wdata     = {val_ff, key_ff};
      ram_raddr     = '0;
      scan_issue    = 1'b0;
      match         = 1'b0;
      finish_go     = 1'b0;

      // result beat taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         kvt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in       = req_tdata[kvt_pkg::OP_W-1:0];
               key_in      = req_tdata[kvt_pkg::OP_W +: kvt_pkg::KEY_W];
               // bytes beyond the value size are dropped, so they read back as zero
               val_in      = req_value_full[VALUE_W-1:0];
               idx_in      = '0;
               cmp_pend_in = 1'b0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               state_in    = kvt_pkg::ST_SCAN;
            end
         end

         kvt_pkg::ST_SCAN: begin
            // read side: one entry per cycle, data back in the next cycle
            scan_issue = (idx_ff < CNT_W'(TABLE_ENTRIES));
            if (scan_issue) begin
               ram_raddr   = idx_ff[IDX_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
               cmp_pend_in = 1'b1;
               cmp_idx_in  = idx_ff[IDX_W-1:0];
               if (!valid_ff[idx_ff[IDX_W-1:0]] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = idx_ff[IDX_W-1:0];
               end
            end else begin
               cmp_pend_in = 1'b0;
            end
            // compare side: keys match bit for bit, valid entries only
            if (cmp_pend_ff) begin
               match = valid_ff[cmp_idx_ff] && (rd_key == key_ff);
               if (match) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = cmp_idx_ff;
                  found_in    = rd_value;
                  cmp_pend_in = 1'b0;
                  state_in    = kvt_pkg::ST_FINISH;
               end else if (cmp_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  state_in = kvt_pkg::ST_FINISH;
               end
            end
         end

         kvt_pkg::ST_FINISH: begin
            // wait until the result register is free
            finish_go = !rsp_valid_ff || rsp_tready;
            if (finish_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = kvt_pkg::STATUS_NOT_FOUND;
               rsp_value_in  = '0;
               unique case (op_ff)
                  kvt_pkg::OP_INSERT: begin
                     if (hit_ff || free_ff) begin
                        ram_we           = 1'b1;
                        valid_in[wr_idx] = 1'b1;
                        rsp_status_in    = kvt_pkg::STATUS_DONE;
                     end else begin
                        rsp_status_in = kvt_pkg::STATUS_FULL;
                     end
                  end
                  kvt_pkg::OP_SEARCH: begin
                     if (hit_ff) begin
                        rsp_status_in = kvt_pkg::STATUS_DONE;
                        rsp_value_in  = kvt_pkg::VALUE_FULL_W'(found_ff);
                     end
                  end
                  kvt_pkg::OP_DELETE: begin
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                        rsp_status_in        = kvt_pkg::STATUS_DONE;
                     end
                  end
                  default: begin
                     // unused code: no change, reported as not found
                  end
               endcase
               state_in = kvt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = kvt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvt_pkg::ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_pend_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_pend_ff  <= cmp_pend_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         idx_ff       <= idx_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

`ifndef SYNTHESIS
   // an accepted request starts a scan
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == kvt_pkg::ST_SCAN))
      else $error("request beat did not start a scan");

   // a successful insert leaves its entry valid
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kvt_pkg::ST_FINISH && finish_go && op_ff == kvt_pkg::OP_INSERT
       && (hit_ff || free_ff)) |=> valid_ff[$past(wr_idx)])
      else $error("inserted entry not marked valid");

   // a delete that hits leaves its entry free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kvt_pkg::ST_FINISH && finish_go && op_ff == kvt_pkg::OP_DELETE
       && hit_ff) |=> !valid_ff[$past(hit_idx_ff)])
      else $error("deleted entry still valid");

   // table full is reported only when every entry is in use
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kvt_pkg::ST_FINISH && finish_go
       && rsp_status_in == kvt_pkg::STATUS_FULL) |-> (&valid_ff))
      else $error("full reported with a free entry");

   // a result carries data only when its status is done, as on a search hit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != kvt_pkg::STATUS_DONE) |-> (rsp_value_ff == '0))
      else $error("value returned on a miss");
`endif

endmodule

`default_nettype wire

[bench/key_value_table_tb.sv]
// ----------------------------------------------------------------------------
// key_value_table_tb: self-checking bench for the key/value table
// Drives insert, search and delete requests over the request stream and
// compares every result beat with a shadow copy of the table or a typed result. A
// short directed pass covers empty, extreme, update, full and unused-code cases,
// then random traffic over a small key pool fills and drains the table many times.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table_tb;

   localparam int TABLE_ENTRIES = kvt_pkg::TABLE_ENTRIES_DEF;
   localparam int VALUE_BYTES   = kvt_pkg::VALUE_BYTES_DEF;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int KEY_POOL      = 24;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 4;

   // the only request code the package leaves unnamed
   localparam logic [kvt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   // value bytes past VALUE_BYTES are stored as zero
   localparam logic [kvt_pkg::VALUE_FULL_W-1:0] VALUE_MASK = (VALUE_BYTES >= 20) ?
      {kvt_pkg::VALUE_FULL_W{1'b1}} :
      ((kvt_pkg::VALUE_FULL_W'(1) << (8 * VALUE_BYTES)) - kvt_pkg::VALUE_FULL_W'(1));

   typedef struct packed {
      logic [kvt_pkg::OP_W-1:0]         op;
      logic [kvt_pkg::KEY_W-1:0]        key;
      logic [kvt_pkg::VALUE_FULL_W-1:0] value;   // byte 0 in the low bits
   } kv_req_type;

   typedef struct packed {
      logic [kvt_pkg::STATUS_W-1:0]     status;
      logic [kvt_pkg::VALUE_FULL_W-1:0] found;
   } kv_rsp_type;

   typedef struct {
      kv_req_type req;
      bit         typed;   // result written out by hand instead of predicted
      kv_rsp_type want;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   // fields from bit 0: operation[2], key[32], value_bytes_0_7[64],
   // value_bytes_8_15[64], value_bytes_16_19[32], zero pad[6]
   logic [kvt_pkg::REQ_W-1:0] req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // fields from bit 0: status[2], found_value_0_7[64],
   // found_value_8_15[64], found_value_16_19[32], zero pad[6]
   logic [kvt_pkg::RSP_W-1:0] rsp_tdata;

   // shadow of the table contents
   bit                               shadow_valid [TABLE_ENTRIES];
   logic [kvt_pkg::KEY_W-1:0]        shadow_key   [TABLE_ENTRIES];
   logic [kvt_pkg::VALUE_FULL_W-1:0] shadow_value [TABLE_ENTRIES];

   kv_rsp_type   awaited_rsp [$];   // results owed by the table, oldest first
   stim_row_type directed_rows [$];
   logic [kvt_pkg::KEY_W-1:0] key_pool [KEY_POOL];

   // side info that travels beside the request beat, not on the bus
   bit         beat_typed;
   kv_rsp_type beat_want;

   int cycle_count;
   int error_count;
   int checked_count;
   int burst_left;
   int stall_mode;
   int n_insert, n_full, n_search, n_hit, n_delete, n_unused;

   key_value_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // shadow table: one request in, the result it owes out
   // ------------------------------------------------------------------------
   function automatic kv_rsp_type apply_request(kv_req_type r);
      kv_rsp_type o;
      int         hit;
      int         slot;
      int         i;
      o.status = kvt_pkg::STATUS_NOT_FOUND;
      o.found  = '0;
      hit = -1;
      for (i = 0; i < TABLE_ENTRIES; i++)
         if (hit < 0 && shadow_valid[i] && shadow_key[i] == r.key)
            hit = i;
      case (r.op)
         kvt_pkg::OP_INSERT: begin
            slot = hit;
            // new key goes to the lowest free entry
            for (i = 0; i < TABLE_ENTRIES; i++)
               if (slot < 0 && !shadow_valid[i])
                  slot = i;
            if (slot < 0) begin
               o.status = kvt_pkg::STATUS_FULL;
            end else begin
               shadow_valid[slot] = 1'b1;
               shadow_key[slot]   = r.key;
               shadow_value[slot] = r.value & VALUE_MASK;
               o.status = kvt_pkg::STATUS_DONE;
            end
         end
         kvt_pkg::OP_SEARCH: begin
            if (hit >= 0) begin
               o.status = kvt_pkg::STATUS_DONE;
               o.found  = shadow_value[hit];
            end
         end
         kvt_pkg::OP_DELETE: begin
            if (hit >= 0) begin
               shadow_valid[hit] = 1'b0;
               o.status = kvt_pkg::STATUS_DONE;
            end
         end
         default: ;   // unused code: table untouched, not found
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [kvt_pkg::VALUE_FULL_W-1:0] got,
                                  logic [kvt_pkg::VALUE_FULL_W-1:0] want);
      $display("mismatch on result %0d, %s: got %h, expected %h",
               checked_count, field, got, want);
      error_count++;
   endtask

   task automatic add_row(logic [kvt_pkg::OP_W-1:0] op, logic [kvt_pkg::KEY_W-1:0] key,
                          logic [kvt_pkg::VALUE_FULL_W-1:0] value, bit typed,
                          logic [kvt_pkg::STATUS_W-1:0] status,
                          logic [kvt_pkg::VALUE_FULL_W-1:0] found);
      stim_row_type row;
      row.req   = '{op: op, key: key, value: value};
      row.typed = typed;
      row.want  = '{status: status, found: found};
      directed_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------------
   // request side: one beat, held until taken; called and returns at negedge
   // ------------------------------------------------------------------------
   task automatic send_beat(kv_req_type r, bit typed, kv_rsp_type want);
      req_tdata  <= {{(kvt_pkg::REQ_W - kvt_pkg::OP_W - kvt_pkg::KEY_W
                       - kvt_pkg::VALUE_FULL_W){1'b0}},
                     r.value, r.key, r.op};
      req_tvalid <= 1'b1;
      beat_typed <= typed;
      beat_want  <= want;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
      // bursts of random length, random gaps, now and then a long clean run
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
      end
   endtask

   // hold off until the table has answered everything sent so far
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side: receiver stalls on its own pattern, changing at negedge
   // ------------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      stall_mode = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 149) == 0)
            stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0:       rsp_tready <= 1'b1;                        // always ready
            1:       rsp_tready <= 1'($urandom_range(0, 1));    // coin toss
            default: rsp_tready <= ($urandom_range(0, 7) == 0); // long stalls
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // monitor: request beats feed the shadow table, result beats are checked
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      kv_req_type r;
      kv_rsp_type pred;
      kv_rsp_type want;
      kv_rsp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r.op    = req_tdata[kvt_pkg::OP_W-1:0];
            r.key   = req_tdata[kvt_pkg::OP_W +: kvt_pkg::KEY_W];
            r.value = req_tdata[kvt_pkg::OP_W + kvt_pkg::KEY_W +: kvt_pkg::VALUE_FULL_W];
            pred = apply_request(r);
            awaited_rsp.push_back(beat_typed ? beat_want : pred);
            case (r.op)
               kvt_pkg::OP_INSERT: begin
                  n_insert++;
                  if (pred.status == kvt_pkg::STATUS_FULL)
                     n_full++;
               end
               kvt_pkg::OP_SEARCH: begin
                  n_search++;
                  if (pred.status == kvt_pkg::STATUS_DONE)
                     n_hit++;
               end
               kvt_pkg::OP_DELETE: n_delete++;
               default:            n_unused++;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[kvt_pkg::STATUS_W-1:0];
            got.found  = rsp_tdata[kvt_pkg::STATUS_W +: kvt_pkg::VALUE_FULL_W];
            if (awaited_rsp.size() == 0) begin
               report_mismatch("beat with no request outstanding, status",
                               kvt_pkg::VALUE_FULL_W'(got.status), '0);
            end else begin
               want = awaited_rsp.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", kvt_pkg::VALUE_FULL_W'(got.status),
                                  kvt_pkg::VALUE_FULL_W'(want.status));
               if (got.found[63:0] !== want.found[63:0])
                  report_mismatch("found_value_0_7",
                                  kvt_pkg::VALUE_FULL_W'(got.found[63:0]),
                                  kvt_pkg::VALUE_FULL_W'(want.found[63:0]));
               if (got.found[127:64] !== want.found[127:64])
                  report_mismatch("found_value_8_15",
                                  kvt_pkg::VALUE_FULL_W'(got.found[127:64]),
                                  kvt_pkg::VALUE_FULL_W'(want.found[127:64]));
               if (got.found[159:128] !== want.found[159:128])
                  report_mismatch("found_value_16_19",
                                  kvt_pkg::VALUE_FULL_W'(got.found[159:128]),
                                  kvt_pkg::VALUE_FULL_W'(want.found[159:128]));
            end
            checked_count++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, awaited_rsp.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      kv_req_type r;
      kv_rsp_type none;
      int         pick;
      bit         filling;
      int         i;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      beat_typed = 1'b0;
      beat_want  = '0;
      none       = '0;
      burst_left = 1;
      for (i = 0; i < TABLE_ENTRIES; i++)
         shadow_valid[i] = 1'b0;

      // directed table
      add_row(kvt_pkg::OP_SEARCH, 32'h0000_0000, '0, 1'b1,
              kvt_pkg::STATUS_NOT_FOUND, '0);                              // empty
      add_row(kvt_pkg::OP_INSERT, 32'h8000_0000, '1, 1'b1,
              kvt_pkg::STATUS_DONE, '0);                                   // min key
      add_row(kvt_pkg::OP_INSERT, 32'h7fff_ffff, '0, 1'b1,
              kvt_pkg::STATUS_DONE, '0);                                   // max key
      add_row(kvt_pkg::OP_SEARCH, 32'h8000_0000, '0, 1'b1,
              kvt_pkg::STATUS_DONE, '1);
      add_row(kvt_pkg::OP_INSERT, 32'h8000_0000, {20{8'h5a}}, 1'b1,
              kvt_pkg::STATUS_DONE, '0);                                   // update
      add_row(kvt_pkg::OP_SEARCH, 32'h8000_0000, '1, 1'b0,
              kvt_pkg::STATUS_DONE, '0);
      add_row(OP_UNUSED, 32'h8000_0000, '1, 1'b1,
              kvt_pkg::STATUS_NOT_FOUND, '0);
      add_row(kvt_pkg::OP_DELETE, 32'h7fff_ffff, '0, 1'b1,
              kvt_pkg::STATUS_DONE, '0);
      add_row(kvt_pkg::OP_DELETE, 32'h7fff_ffff, '0, 1'b1,
              kvt_pkg::STATUS_NOT_FOUND, '0);                              // missing
      // fill the remaining entries: keys -1, 0, 1 .. 13
      for (i = -1; i < TABLE_ENTRIES - 2; i++)
         add_row(kvt_pkg::OP_INSERT, 32'(i), {5{32'(i) ^ 32'hc3a5_0f96}}, 1'b0,
                 kvt_pkg::STATUS_DONE, '0);
      add_row(kvt_pkg::OP_INSERT, 32'h7fff_0000, '1, 1'b1,
              kvt_pkg::STATUS_FULL, '0);                                   // full
      add_row(kvt_pkg::OP_INSERT, 32'hffff_ffff, '0, 1'b1,
              kvt_pkg::STATUS_DONE, '0);                                   // update when full

      // random key pool, extremes first; more keys than entries
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      for (i = 4; i < KEY_POOL; i++)
         key_pool[i] = $urandom;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k])
         send_beat(directed_rows[k].req, directed_rows[k].typed,
                   directed_rows[k].want);
      wait_quiet();

      // random traffic: alternate fill-heavy and drain-heavy stretches
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2)
            wait_quiet();
         filling = ((i / 120) % 2) == 0;
         pick = $urandom_range(0, 99);
         if (pick < (filling ? 55 : 15))
            r.op = kvt_pkg::OP_INSERT;
         else if (pick < (filling ? 80 : 40))
            r.op = kvt_pkg::OP_SEARCH;
         else if (pick < 95)
            r.op = kvt_pkg::OP_DELETE;
         else
            r.op = OP_UNUSED;
         r.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                              : 32'($urandom);
         case ($urandom_range(0, 19))
            0:       r.value = '0;
            1:       r.value = '1;
            default: r.value = {$urandom, $urandom, $urandom, $urandom, $urandom};
         endcase
         send_beat(r, 1'b0, none);
      end

      // drain: everything owed, then a latency's worth of quiet
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("ran %0d requests: %0d inserts (%0d refused as full), %0d searches "
               , n_insert + n_search + n_delete + n_unused, n_insert, n_full, n_search);
      $display("  (%0d hits), %0d deletes, %0d unused-code; %0d results checked, %0d errors",
               n_hit, n_delete, n_unused, checked_count, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
